// ===== rtl/core/tsrr_pkg.sv =====
// Shared types and constants for the thread slot round-robin scheduler.
`default_nettype none

package tsrr_pkg;

  localparam int SlotW = 4;
  localparam int CmdW  = 3;
  localparam int StatW = 3;

  typedef enum logic [CmdW-1:0] {
    CMD_ALLOC  = 3'd0,
    CMD_FREE   = 3'd1,
    CMD_ADD    = 3'd2,
    CMD_REMOVE = 3'd3,
    CMD_NEXT   = 3'd4,
    CMD_SETCUR = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    STAT_OK       = 3'd0,
    STAT_NOSWITCH = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_BADSLOT  = 3'd4
  } status_e;

  typedef struct packed {
    logic             alloc_start;
    logic             free_en;
    logic [SlotW-1:0] free_slot;
  } pool_req_t;

  typedef struct packed {
    logic             done;
    logic             found;
    logic [SlotW-1:0] slot;
  } pool_rsp_t;

  typedef struct packed {
    logic             valid;
    logic [SlotW-1:0] slot;
    status_e          status;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/thread_slot_round_robin_scheduler.sv =====
// Thread slot round-robin scheduler: slot pool plus a doubly linked ready ring.
//
// Input channel (in_valid_i / in_stall_o) carries one command per transaction:
// allocate, free, add ready, remove ready, next ready or set current. Each
// command yields exactly one transaction on the output channel (out_valid_o /
// out_stall_i) with result_slot_o and status_o.
// Commands run one at a time. The ring links sit in two synchronous memories
// read in the acceptance cycle, so a command passes through an execute state
// and a done state before the next acceptance; add to a non-empty ring also
// needs a second write state (two writes per link memory). Allocate searches
// the in-use bits up to sixteen slots per cycle in its own scan state.
// The result is loaded into the output register from the done state. A
// stalled result holds in the output register while the next command is
// accepted and executed; that command then waits before its own result
// until the register frees.
// Reset empties the pool and the ring and clears the current thread; the link
// memories are not cleared and need no clearing pass.
`default_nettype none

module thread_slot_round_robin_scheduler #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [tsrr_pkg::CmdW-1:0]         command_i,
  input  wire logic [tsrr_pkg::SlotW-1:0]        slot_i,
  input  wire logic                              slot_valid_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic      [tsrr_pkg::SlotW-1:0]        result_slot_o,
  output logic      [tsrr_pkg::StatW-1:0]        status_o
);

  localparam int SW = $clog2(NUM_SLOTS);

  tsrr_pkg::pool_req_t          pool_req;
  tsrr_pkg::pool_rsp_t          pool_rsp;
  tsrr_pkg::result_t            rsp;
  logic                         busy;
  logic                         out_free;
  logic [SW-1:0]                rd_addr;
  logic [SW-1:0]                next_rdata;
  logic [SW-1:0]                prev_rdata;
  logic                         next_we;
  logic [SW-1:0]                next_waddr;
  logic [SW-1:0]                next_wdata;
  logic                         prev_we;
  logic [SW-1:0]                prev_waddr;
  logic [SW-1:0]                prev_wdata;

  logic                         out_valid_q;
  logic [tsrr_pkg::SlotW-1:0]   out_slot_q;
  tsrr_pkg::status_e            out_status_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy;

  tsrr_ctrl #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .command_i    (command_i),
    .slot_i       (slot_i),
    .slot_valid_i (slot_valid_i),
    .busy_o       (busy),
    .out_free_i   (out_free),
    .rsp_o        (rsp),
    .pool_req_o   (pool_req),
    .pool_rsp_i   (pool_rsp),
    .rd_addr_o    (rd_addr),
    .next_rdata_i (next_rdata),
    .prev_rdata_i (prev_rdata),
    .next_we_o    (next_we),
    .next_waddr_o (next_waddr),
    .next_wdata_o (next_wdata),
    .prev_we_o    (prev_we),
    .prev_waddr_o (prev_waddr),
    .prev_wdata_o (prev_wdata)
  );

  tsrr_slot_pool #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_slot_pool (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (pool_req),
    .rsp_o  (pool_rsp)
  );

  tsrr_link_mem #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_link_mem (
    .clk_i        (clk_i),
    .rd_addr_i    (rd_addr),
    .next_we_i    (next_we),
    .next_waddr_i (next_waddr),
    .next_wdata_i (next_wdata),
    .prev_we_i    (prev_we),
    .prev_waddr_i (prev_waddr),
    .prev_wdata_i (prev_wdata),
    .next_rdata_o (next_rdata),
    .prev_rdata_o (prev_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp.valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp.valid) begin
      out_slot_q   <= rsp.slot;
      out_status_q <= rsp.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_slot_o = out_slot_q;
  assign status_o      = out_status_q;

endmodule

`default_nettype wire

// ===== rtl/core/tsrr_link_mem.sv =====
// Next and previous link memories of the ready ring, with registered read data.
`default_nettype none

module tsrr_link_mem #(
  parameter int NUM_SLOTS = 16,
  localparam int SW = $clog2(NUM_SLOTS)
) (
  input  wire logic          clk_i,
  input  wire logic [SW-1:0] rd_addr_i,
  input  wire logic          next_we_i,
  input  wire logic [SW-1:0] next_waddr_i,
  input  wire logic [SW-1:0] next_wdata_i,
  input  wire logic          prev_we_i,
  input  wire logic [SW-1:0] prev_waddr_i,
  input  wire logic [SW-1:0] prev_wdata_i,
  output logic      [SW-1:0] next_rdata_o,
  output logic      [SW-1:0] prev_rdata_o
);

  logic [SW-1:0] next_mem [NUM_SLOTS];
  logic [SW-1:0] prev_mem [NUM_SLOTS];
  logic [SW-1:0] next_rdata_q;
  logic [SW-1:0] prev_rdata_q;

  always_ff @(posedge clk_i) begin
    if (next_we_i) begin
      next_mem[next_waddr_i] <= next_wdata_i;
    end
    next_rdata_q <= next_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (prev_we_i) begin
      prev_mem[prev_waddr_i] <= prev_wdata_i;
    end
    prev_rdata_q <= prev_mem[rd_addr_i];
  end

  assign next_rdata_o = next_rdata_q;
  assign prev_rdata_o = prev_rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/tsrr_slot_pool.sv =====
// Slot in-use bits with a lowest-free search over groups of up to sixteen slots.
`default_nettype none

module tsrr_slot_pool #(
  parameter int NUM_SLOTS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tsrr_pkg::pool_req_t req_i,
  output tsrr_pkg::pool_rsp_t      rsp_o
);

  localparam int SW   = $clog2(NUM_SLOTS);
  localparam int GRP  = (NUM_SLOTS < 16) ? NUM_SLOTS : 16;
  localparam int NGRP = (NUM_SLOTS + GRP - 1) / GRP;
  localparam int GW   = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int OW   = $clog2(GRP);

  logic [NUM_SLOTS-1:0] in_use_q;
  logic                 scan_q;
  logic [GW-1:0]        grp_q;

  logic [NGRP*GRP-1:0]  in_use_pad;
  logic [GRP-1:0]       grp_bits;
  logic                 found;
  logic [OW-1:0]        off;
  logic [SW-1:0]        free_idx;
  logic                 last_grp;

  always_comb begin
    // padding past the last slot reads as taken
    in_use_pad                = '1;
    in_use_pad[NUM_SLOTS-1:0] = in_use_q;
    grp_bits = in_use_pad[int'(grp_q)*GRP +: GRP];
    found    = 1'b0;
    off      = '0;
    for (int i = GRP - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        found = 1'b1;
        off   = OW'(i);
      end
    end
    free_idx = SW'(int'(grp_q) * GRP + int'(off));
    last_grp = (int'(grp_q) == NGRP - 1);
  end

  assign rsp_o.done  = scan_q && (found || last_grp);
  assign rsp_o.found = scan_q && found;
  assign rsp_o.slot  = tsrr_pkg::SlotW'(free_idx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      scan_q   <= 1'b0;
      grp_q    <= '0;
    end else begin
      if (req_i.alloc_start) begin
        scan_q <= 1'b1;
        grp_q  <= '0;
      end else if (scan_q) begin
        if (found || last_grp) begin
          scan_q <= 1'b0;
          if (found) begin
            in_use_q[free_idx] <= 1'b1;
          end
        end else begin
          grp_q <= grp_q + GW'(1);
        end
      end
      if (req_i.free_en) begin
        in_use_q[SW'(req_i.free_slot)] <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tsrr_ctrl.sv =====
// Command sequencer: ring head, membership, current thread and link updates.
`default_nettype none

module tsrr_ctrl #(
  parameter int NUM_SLOTS = 16,
  localparam int SW = $clog2(NUM_SLOTS)
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  input  wire logic [tsrr_pkg::CmdW-1:0]        command_i,
  input  wire logic [tsrr_pkg::SlotW-1:0]       slot_i,
  input  wire logic                             slot_valid_i,
  output logic                                  busy_o,
  input  wire logic                             out_free_i,
  output tsrr_pkg::result_t                     rsp_o,
  output tsrr_pkg::pool_req_t                   pool_req_o,
  input  wire tsrr_pkg::pool_rsp_t              pool_rsp_i,
  output logic      [SW-1:0]                    rd_addr_o,
  input  wire logic [SW-1:0]                    next_rdata_i,
  input  wire logic [SW-1:0]                    prev_rdata_i,
  output logic                                  next_we_o,
  output logic      [SW-1:0]                    next_waddr_o,
  output logic      [SW-1:0]                    next_wdata_o,
  output logic                                  prev_we_o,
  output logic      [SW-1:0]                    prev_waddr_o,
  output logic      [SW-1:0]                    prev_wdata_o
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_EXEC   = 5'b00010,
    ST_WRITE2 = 5'b00100,
    ST_SCAN   = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e                       state_q, state_d;
  tsrr_pkg::cmd_e               cmd_q, cmd_d;
  logic [tsrr_pkg::SlotW-1:0]   slot_q, slot_d;
  logic                         sv_q, sv_d;
  logic [tsrr_pkg::SlotW-1:0]   res_q, res_d;
  tsrr_pkg::status_e            st_q, st_d;
  logic [SW-1:0]                head_q, head_d;
  logic                         nonempty_q, nonempty_d;
  logic [tsrr_pkg::SlotW-1:0]   cur_q, cur_d;
  logic                         cur_valid_q, cur_valid_d;
  logic [NUM_SLOTS-1:0]         in_ring_q, in_ring_d;

  logic [SW-1:0]                sidx;
  logic                         in_rng;

  assign sidx   = SW'(slot_q);
  assign in_rng = (int'(slot_q) < NUM_SLOTS);
  assign busy_o = (state_q != ST_IDLE);

  // remove reads the slot's own links, add and next ready read around the head
  assign rd_addr_o = (tsrr_pkg::cmd_e'(command_i) == tsrr_pkg::CMD_REMOVE) ? SW'(slot_i)
                                                                           : head_q;

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    slot_d       = slot_q;
    sv_d         = sv_q;
    res_d        = res_q;
    st_d         = st_q;
    head_d       = head_q;
    nonempty_d   = nonempty_q;
    cur_d        = cur_q;
    cur_valid_d  = cur_valid_q;
    in_ring_d    = in_ring_q;
    pool_req_o   = '0;
    rsp_o        = '0;
    next_we_o    = 1'b0;
    next_waddr_o = sidx;
    next_wdata_o = sidx;
    prev_we_o    = 1'b0;
    prev_waddr_o = sidx;
    prev_wdata_o = sidx;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d  = tsrr_pkg::cmd_e'(command_i);
          slot_d = slot_i;
          sv_d   = slot_valid_i;
          res_d  = '0;
          st_d   = tsrr_pkg::STAT_OK;
          if (tsrr_pkg::cmd_e'(command_i) == tsrr_pkg::CMD_ALLOC) begin
            pool_req_o.alloc_start = 1'b1;
            state_d                = ST_SCAN;
          end else begin
            state_d = ST_EXEC;
          end
        end
      end

      ST_SCAN: begin
        if (pool_rsp_i.done) begin
          if (pool_rsp_i.found) begin
            res_d = pool_rsp_i.slot;
            st_d  = tsrr_pkg::STAT_OK;
          end else begin
            st_d  = tsrr_pkg::STAT_FULL;
          end
          state_d = ST_DONE;
        end
      end

      ST_EXEC: begin
        state_d = ST_DONE;
        case (cmd_q)
          tsrr_pkg::CMD_FREE: begin
            if (!in_rng) begin
              st_d = tsrr_pkg::STAT_BADSLOT;
            end else begin
              pool_req_o.free_en   = 1'b1;
              pool_req_o.free_slot = slot_q;
            end
          end
          tsrr_pkg::CMD_ADD: begin
            if (!in_rng || in_ring_q[sidx]) begin
              st_d = tsrr_pkg::STAT_BADSLOT;
            end else begin
              in_ring_d[sidx] = 1'b1;
              if (nonempty_q) begin
                // splice after the tail; head side follows in the next cycle
                next_we_o    = 1'b1;
                next_waddr_o = prev_rdata_i;
                next_wdata_o = sidx;
                prev_we_o    = 1'b1;
                prev_waddr_o = sidx;
                prev_wdata_o = prev_rdata_i;
                state_d      = ST_WRITE2;
              end else begin
                head_d     = sidx;
                nonempty_d = 1'b1;
                next_we_o  = 1'b1;
                prev_we_o  = 1'b1;
              end
            end
          end
          tsrr_pkg::CMD_REMOVE: begin
            if (!in_rng || !in_ring_q[sidx]) begin
              st_d = tsrr_pkg::STAT_BADSLOT;
            end else begin
              in_ring_d[sidx] = 1'b0;
              if (next_rdata_i == sidx) begin
                nonempty_d = 1'b0;
                head_d     = '0;
              end else begin
                next_we_o    = 1'b1;
                next_waddr_o = prev_rdata_i;
                next_wdata_o = next_rdata_i;
                prev_we_o    = 1'b1;
                prev_waddr_o = next_rdata_i;
                prev_wdata_o = prev_rdata_i;
                if (head_q == sidx) begin
                  head_d = next_rdata_i;
                end
              end
            end
          end
          tsrr_pkg::CMD_NEXT: begin
            if (!nonempty_q) begin
              st_d = tsrr_pkg::STAT_EMPTY;
            end else begin
              res_d  = tsrr_pkg::SlotW'(head_q);
              head_d = next_rdata_i;
              st_d   = (cur_valid_q && cur_q == tsrr_pkg::SlotW'(head_q))
                       ? tsrr_pkg::STAT_NOSWITCH : tsrr_pkg::STAT_OK;
            end
          end
          tsrr_pkg::CMD_SETCUR: begin
            if (!sv_q) begin
              cur_valid_d = 1'b0;
              cur_d       = '0;
            end else if (!in_rng) begin
              st_d = tsrr_pkg::STAT_BADSLOT;
            end else begin
              cur_valid_d = 1'b1;
              cur_d       = slot_q;
            end
          end
          default: begin
          end
        endcase
      end

      ST_WRITE2: begin
        next_we_o    = 1'b1;
        next_waddr_o = sidx;
        next_wdata_o = head_q;
        prev_we_o    = 1'b1;
        prev_waddr_o = head_q;
        prev_wdata_o = sidx;
        state_d      = ST_DONE;
      end

      ST_DONE: begin
        if (out_free_i) begin
          rsp_o.valid  = 1'b1;
          rsp_o.slot   = res_q;
          rsp_o.status = st_q;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      nonempty_q  <= 1'b0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      in_ring_q   <= '0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      nonempty_q  <= nonempty_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      in_ring_q   <= in_ring_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    slot_q <= slot_d;
    sv_q   <= sv_d;
    res_q  <= res_d;
    st_q   <= st_d;
  end

endmodule

`default_nettype wire

// ===== test/tb_thread_slot_round_robin_scheduler.sv =====
// Testbench for the thread slot round-robin scheduler: directed cases, then random traffic.
module tb_thread_slot_round_robin_scheduler;
  import tsrr_pkg::*;

  localparam int Slots = 16;
  localparam int PhaseItems = 325;
  localparam logic [CmdW-1:0] CmdSpareLo = 3'd6;
  localparam logic [CmdW-1:0] CmdSpareHi = 3'd7;

  typedef struct {
    logic [SlotW-1:0] slot;
    status_e          status;
  } sched_result_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic [CmdW-1:0]  command;
  logic [SlotW-1:0] slot;
  logic             slot_valid;
  logic             out_valid;
  logic             out_stall;
  logic [SlotW-1:0] result_slot;
  logic [StatW-1:0] status;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned error_count;

  // scheduler state as the block should hold it
  bit               slot_used[Slots];
  bit               slot_ready[Slots];
  logic [SlotW-1:0] link_fwd[Slots];
  logic [SlotW-1:0] link_back[Slots];
  logic [SlotW-1:0] head_slot;
  bit               ring_live;
  logic [SlotW-1:0] running_slot;
  bit               running_live;

  sched_result_t pending_results[$];

  thread_slot_round_robin_scheduler #(
    .NUM_SLOTS(Slots)
  ) i_dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .command_i    (command),
    .slot_i       (slot),
    .slot_valid_i (slot_valid),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .result_slot_o(result_slot),
    .status_o     (status)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic sched_result_t schedule_command(input logic [CmdW-1:0] cmd,
                                                     input logic [SlotW-1:0] s,
                                                     input logic sv);
    sched_result_t    r;
    logic [SlotW-1:0] tail;
    logic [SlotW-1:0] nx;
    logic [SlotW-1:0] pv;
    r.slot = '0;
    r.status = STAT_OK;
    case (cmd)
      CMD_ALLOC: begin
        r.status = STAT_FULL;
        for (int i = 0; i < Slots; i++) begin
          if (!slot_used[i] && r.status == STAT_FULL) begin
            slot_used[i] = 1'b1;
            r.slot = i[SlotW-1:0];
            r.status = STAT_OK;
          end
        end
      end
      CMD_FREE: slot_used[s] = 1'b0;
      CMD_ADD: begin
        if (slot_ready[s]) begin
          r.status = STAT_BADSLOT;
        end else begin
          if (ring_live) begin
            tail = link_back[head_slot];
            link_fwd[tail] = s;
            link_back[s] = tail;
            link_back[head_slot] = s;
            link_fwd[s] = head_slot;
          end else begin
            head_slot = s;
            link_fwd[s] = s;
            link_back[s] = s;
            ring_live = 1'b1;
          end
          slot_ready[s] = 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (!slot_ready[s]) begin
          r.status = STAT_BADSLOT;
        end else begin
          nx = link_fwd[s];
          pv = link_back[s];
          if (nx == s) begin
            ring_live = 1'b0;
            head_slot = '0;
          end else begin
            link_fwd[pv] = nx;
            link_back[nx] = pv;
            if (head_slot == s) head_slot = nx;
          end
          slot_ready[s] = 1'b0;
        end
      end
      CMD_NEXT: begin
        if (!ring_live) begin
          r.status = STAT_EMPTY;
        end else begin
          r.slot = head_slot;
          head_slot = link_fwd[head_slot];
          r.status = (running_live && running_slot == r.slot) ? STAT_NOSWITCH : STAT_OK;
        end
      end
      CMD_SETCUR: begin
        running_live = sv;
        running_slot = sv ? s : '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Enters and leaves at a falling edge; valid stays high between back-to-back commands.
  task automatic issue_command(input logic [CmdW-1:0] cmd, input logic [SlotW-1:0] s,
                               input logic sv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid   <= 1'b0;
      command    <= CmdW'($urandom_range(7));
      slot       <= SlotW'($urandom_range(Slots - 1));
      slot_valid <= 1'($urandom_range(1));
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    slot       <= s;
    slot_valid <= sv;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(schedule_command(cmd, s, sv));
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    sched_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected transaction: expected none, actual slot %0d status %0d",
                 $time, result_slot, status);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (result_slot !== exp_r.slot) begin
          $display("%0t: result_slot mismatch: expected %0d actual %0d",
                   $time, exp_r.slot, result_slot);
          error_count++;
        end
        if (status !== exp_r.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d",
                   $time, exp_r.status, status);
          error_count++;
        end
      end
    end
  end

  // Picks a slot whose flag equals the wanted value most of the time, otherwise any slot.
  function automatic logic [SlotW-1:0] choose_slot(input bit flags[Slots], input bit want);
    logic [SlotW-1:0] hits[$];
    for (int i = 0; i < Slots; i++) begin
      if (flags[i] == want) hits.push_back(i[SlotW-1:0]);
    end
    if (hits.size() != 0 && $urandom_range(99) < 75) begin
      return hits[$urandom_range(hits.size() - 1)];
    end
    return SlotW'($urandom_range(Slots - 1));
  endfunction

  task automatic test_ring_cases();
    issue_command(CMD_FREE, 4'd5, 1'b0);
    issue_command(CMD_REMOVE, 4'd4, 1'b1);
    issue_command(CMD_ADD, 4'd4, 1'b0);
    issue_command(CMD_ADD, 4'd4, 1'b1);
    issue_command(CMD_ADD, 4'd0, 1'b0);
    issue_command(CMD_SETCUR, 4'd0, 1'b1);
    issue_command(CMD_NEXT, 4'd15, 1'b1);
    issue_command(CMD_NEXT, 4'd0, 1'b0);
    issue_command(CMD_REMOVE, 4'd4, 1'b0);
    issue_command(CMD_FREE, 4'd0, 1'b1);
    issue_command(CMD_REMOVE, 4'd0, 1'b1);
    issue_command(CMD_NEXT, 4'd0, 1'b0);
    issue_command(CMD_SETCUR, 4'd7, 1'b0);
    issue_command(CmdSpareLo, 4'd15, 1'b1);
    issue_command(CmdSpareHi, 4'd10, 1'b0);
  endtask

  task automatic test_pool_exhaustion();
    for (int i = 0; i < Slots; i++) issue_command(CMD_ALLOC, 4'd15, 1'b1);
    issue_command(CMD_ALLOC, 4'd0, 1'b0);
    issue_command(CMD_FREE, 4'd9, 1'b0);
    issue_command(CMD_ALLOC, 4'd3, 1'b1);
  endtask

  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned hold_pct);
    int unsigned      pick;
    logic [CmdW-1:0]  cmd;
    logic [SlotW-1:0] s;
    logic             sv;
    send_idle_pct = idle_pct;
    stall_pct = hold_pct;
    for (int n = 0; n < PhaseItems; n++) begin
      pick = $urandom_range(99);
      s = SlotW'($urandom_range(Slots - 1));
      sv = 1'($urandom_range(1));
      if (pick < 14) begin
        cmd = CMD_ALLOC;
      end else if (pick < 24) begin
        cmd = CMD_FREE;
        s = choose_slot(slot_used, 1'b1);
      end else if (pick < 44) begin
        cmd = CMD_ADD;
        s = choose_slot(slot_ready, 1'b0);
      end else if (pick < 58) begin
        cmd = CMD_REMOVE;
        s = choose_slot(slot_ready, 1'b1);
      end else if (pick < 82) begin
        cmd = CMD_NEXT;
      end else if (pick < 96) begin
        cmd = CMD_SETCUR;
        s = choose_slot(slot_ready, 1'b1);
        sv = ($urandom_range(99) < 80);
      end else if (pick < 98) begin
        cmd = CmdSpareLo;
      end else begin
        cmd = CmdSpareHi;
      end
      issue_command(cmd, s, sv);
    end
    drain_results();
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    command = CMD_ALLOC;
    slot = '0;
    slot_valid = 1'b0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    error_count = 0;
    slot_used = '{default: 1'b0};
    slot_ready = '{default: 1'b0};
    link_fwd = '{default: '0};
    link_back = '{default: '0};
    head_slot = '0;
    ring_live = 1'b0;
    running_slot = '0;
    running_live = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_ring_cases();
    test_pool_exhaustion();
    drain_results();
    test_random_traffic(0, 0);
    test_random_traffic(54, 0);
    test_random_traffic(0, 54);
    test_random_traffic(26, 26);

    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
